// ===== rtl/sbdb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbdb_pkg
// shared types and constants of the sprite blitter with double sprite buffer
// ----------------------------------------------------------------------------
`default_nettype none

package sbdb_pkg;

    // item actions
    localparam logic [2:0] ACT_ROM    = 3'd0;
    localparam logic [2:0] ACT_COLOR  = 3'd1;
    localparam logic [2:0] ACT_REG    = 3'd2;
    localparam logic [2:0] ACT_VBLANK = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    // control register indexes
    localparam logic [3:0] REG_MODE    = 4'd0;
    localparam logic [3:0] REG_WIDTH   = 4'd1;
    localparam logic [3:0] REG_HEIGHT  = 4'd2;
    localparam logic [3:0] REG_XORG    = 4'd3;
    localparam logic [3:0] REG_YORG    = 4'd4;
    localparam logic [3:0] REG_HI      = 4'd5;
    localparam logic [3:0] REG_DSEL    = 4'd6;
    localparam logic [3:0] REG_BASE_LO = 4'd7;
    localparam logic [3:0] REG_BASE_HI = 4'd8;
    localparam logic [3:0] REG_DRAW    = 4'd9;

    // memories
    localparam int ROM_DEPTH   = 98304;
    localparam int COLOR_DEPTH = 1024;
    localparam int MAP_DEPTH   = 131072;

    // rom regions
    localparam logic [16:0] D_ROM_BASE     = 17'h10000;
    localparam logic [16:0] EF_ROM_BASE    = 17'h12000;
    localparam logic [16:0] HI_ROM_BASE    = 17'h14000;
    localparam logic [16:0] EF_HIGH_OFFSET = 17'h01000;
    localparam logic [16:0] HI_SECOND_OFF  = 17'h02000;
    localparam logic [12:0] HI_BANK_STEP   = 13'h0800;
    localparam logic [12:0] HI_BANK_MASK   = 13'h1800;
    localparam logic [7:0]  DOT_MASK       = 8'h7e;
    localparam logic [3:0]  TRANSPARENT    = 4'h0f;

    // datapath step codes
    typedef enum logic [4:0] {
        STEP_NONE,
        STEP_CLEAR,
        STEP_FILL,
        STEP_READ,
        STEP_R0,
        STEP_R1,
        STEP_R2,
        STEP_R3,
        STEP_R4,
        STEP_R5,
        STEP_D0,
        STEP_D1,
        STEP_D2,
        STEP_D3,
        STEP_D4,
        STEP_D5
    } step_t;

    typedef struct packed {
        logic  accept;
        logic  out_load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic go_draw;
        logic go_fill;
        logic go_read;
        logic x_last;
        logic y_last;
        logic clear_last;
        logic fill_last;
        logic out_busy;
    } sts_t;

    // inversion and carry adder
    function automatic logic [10:0] inv_add(input logic inv, input logic [7:0] b,
                                            input logic [10:0] other);
        logic [7:0] t;
        t = b ^ {8{inv}};
        return 11'({10'b0, inv} + {3'b0, t} + {2'b0, t[7], 8'b0} + other);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sbdb_ram.sv =====
// ----------------------------------------------------------------------------
// sbdb_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sbdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sbdb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbdb_ctrl
// sequencer for clearing, filling, pixel reads and sprite drawing
// ----------------------------------------------------------------------------
`default_nettype none

module sbdb_ctrl
    import sbdb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [16:0] {
        ST_CLEAR   = 17'h00001,
        ST_IDLE    = 17'h00002,
        ST_READ    = 17'h00004,
        ST_RD_DONE = 17'h00008,
        ST_FILL    = 17'h00010,
        ST_R0      = 17'h00020,
        ST_R1      = 17'h00040,
        ST_R2      = 17'h00080,
        ST_R3      = 17'h00100,
        ST_R4      = 17'h00200,
        ST_R5      = 17'h00400,
        ST_D0      = 17'h00800,
        ST_D1      = 17'h01000,
        ST_D2      = 17'h02000,
        ST_D3      = 17'h04000,
        ST_D4      = 17'h08000,
        ST_D5      = 17'h10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.out_load = 1'b0;
        cmd.step     = STEP_NONE;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.step = STEP_CLEAR;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    priority if (sts.go_draw)
                    begin
                        state_next = ST_R0;
                    end
                    else if (sts.go_fill)
                    begin
                        state_next = ST_FILL;
                    end
                    else if (sts.go_read)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.step   = STEP_READ;
                state_next = ST_RD_DONE;
            end
            ST_RD_DONE:
            begin
                cmd.step = STEP_READ;
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                cmd.step = STEP_FILL;
                if (sts.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_R0:
            begin
                cmd.step   = STEP_R0;
                state_next = ST_R1;
            end
            ST_R1:
            begin
                cmd.step   = STEP_R1;
                state_next = ST_R2;
            end
            ST_R2:
            begin
                cmd.step   = STEP_R2;
                state_next = ST_R3;
            end
            ST_R3:
            begin
                cmd.step   = STEP_R3;
                state_next = ST_R4;
            end
            ST_R4:
            begin
                cmd.step   = STEP_R4;
                state_next = ST_R5;
            end
            ST_R5:
            begin
                cmd.step   = STEP_R5;
                state_next = ST_D0;
            end
            ST_D0:
            begin
                cmd.step   = STEP_D0;
                state_next = ST_D1;
            end
            ST_D1:
            begin
                cmd.step   = STEP_D1;
                state_next = ST_D2;
            end
            ST_D2:
            begin
                cmd.step   = STEP_D2;
                state_next = ST_D3;
            end
            ST_D3:
            begin
                cmd.step   = STEP_D3;
                state_next = ST_D4;
            end
            ST_D4:
            begin
                cmd.step   = STEP_D4;
                state_next = ST_D5;
            end
            ST_D5:
            begin
                cmd.step = STEP_D5;
                priority if (!sts.x_last)
                begin
                    state_next = ST_D0;
                end
                else if (!sts.y_last)
                begin
                    state_next = ST_R0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/sbdb_dp.sv =====
// ----------------------------------------------------------------------------
// sbdb_dp
// sprite registers, graphics rom, colour ram, sprite buffers and dot arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module sbdb_dp
    import sbdb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [2:0]  action,
    input  wire logic [16:0] rom_address,
    input  wire logic [9:0]  color_address,
    input  wire logic [3:0]  reg_index,
    input  wire logic [7:0]  value,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [3:0]  pixel,
    input  wire cmd_t        cmd,
    output sts_t             sts
);

    // sprite registers
    logic        disp_reg;
    logic [3:0]  ef_sel_reg;
    logic        flip_h_reg, flip_v_reg;
    logic [6:0]  width_reg, height_reg;
    logic        x_mark_reg, y_mark_reg;
    logic [7:0]  x_org_reg, y_org_reg;
    logic [3:0]  hi_mid_reg;
    logic [1:0]  hi_top_reg;
    logic [5:0]  d_sel_reg;
    logic [15:0] base_reg;
    logic [5:0]  bank_reg;

    // walk state
    logic [16:0] sweep_reg;
    logic [6:0]  x_reg, y_reg;
    logic [7:0]  rd_x_reg, rd_y_reg;
    logic        out_valid_reg;
    logic [3:0]  pixel_reg;

    // per row and per dot working values
    logic [6:0]  line_reg;
    logic [7:0]  adda_lo_reg;
    logic [15:0] sumb_reg;
    logic [10:0] rowx_reg, rowy_reg;
    logic [7:0]  dv_reg;
    logic [10:0] px_reg, py_reg;

    logic        rom_we, color_we, map_we;
    logic [16:0] rom_raddr, map_waddr, map_raddr;
    logic [9:0]  color_raddr;
    logic [7:0]  rom_rd;
    logic [3:0]  color_rd, map_rd, map_wdata, lo_nib;
    logic [11:0] efa;
    logic [12:0] hia, hx, dy_off, dx_off;
    logic [15:0] caddr;
    logic [16:0] dot_addr;
    logic        dot_carry;

    assign rom_we   = cmd.accept && (action == ACT_ROM) && (rom_address < 17'(ROM_DEPTH));
    assign color_we = cmd.accept && (action == ACT_COLOR);

    sbdb_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
        .clk   (clk),
        .we    (rom_we),
        .waddr (rom_address),
        .wdata (value),
        .raddr (rom_raddr),
        .rdata (rom_rd)
    );

    sbdb_ram #(.WIDTH(4), .DEPTH(COLOR_DEPTH)) u_color (
        .clk   (clk),
        .we    (color_we),
        .waddr (color_address),
        .wdata (value[3:0]),
        .raddr (color_raddr),
        .rdata (color_rd)
    );

    sbdb_ram #(.WIDTH(4), .DEPTH(MAP_DEPTH)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (map_raddr),
        .rdata (map_rd)
    );

    // rom offsets
    assign efa    = {1'b1, ef_sel_reg, line_reg};
    assign hia    = ({hi_top_reg, 11'b0} + HI_BANK_STEP) & HI_BANK_MASK
                    | {2'b0, hi_mid_reg, y_reg};
    assign hx     = {hi_top_reg, hi_mid_reg, x_reg};
    assign dy_off = {d_sel_reg, y_reg};
    assign dx_off = {d_sel_reg, x_reg};
    assign caddr  = 16'({8'b0, (dv_reg & DOT_MASK)} >> 1) + sumb_reg;
    assign lo_nib = dv_reg[0] ? rom_rd[7:4] : rom_rd[3:0];

    assign dot_addr  = {disp_reg, py_reg[7:0], px_reg[7:0]};
    assign dot_carry = px_reg[8] | py_reg[8];

    always_comb
    begin
        rom_raddr   = '0;
        color_raddr = '0;
        map_raddr   = {~disp_reg, rd_y_reg, rd_x_reg};
        map_waddr   = dot_addr;
        map_wdata   = color_rd;
        map_we      = 1'b0;
        unique case (cmd.step)
            STEP_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = sweep_reg;
                map_wdata = '0;
            end
            STEP_FILL:
            begin
                map_we    = 1'b1;
                map_waddr = {disp_reg, sweep_reg[15:0]};
                map_wdata = TRANSPARENT;
            end
            STEP_R0: rom_raddr = D_ROM_BASE + {4'b0, dy_off};
            STEP_R1: rom_raddr = EF_ROM_BASE + {5'b0, 1'b1, ef_sel_reg, rom_rd[6:0]};
            STEP_R2: rom_raddr = EF_ROM_BASE + EF_HIGH_OFFSET + {5'b0, efa};
            STEP_R3: rom_raddr = HI_ROM_BASE + {4'b0, hia};
            STEP_R4: rom_raddr = HI_ROM_BASE + HI_SECOND_OFF + {4'b0, hia};
            STEP_D0: rom_raddr = D_ROM_BASE + {4'b0, dx_off};
            STEP_D1: rom_raddr = HI_ROM_BASE + {4'b0, hx};
            STEP_D2: rom_raddr = HI_ROM_BASE + HI_SECOND_OFF + {4'b0, hx};
            STEP_D3: rom_raddr = {1'b0, caddr};
            STEP_D4:
            begin
                color_raddr = {bank_reg, lo_nib};
                map_raddr   = dot_addr;
            end
            STEP_D5:
            begin
                map_we = !dot_carry && (map_rd == TRANSPARENT);
            end
            default:
            begin
            end
        endcase
    end

    // register writes and buffer swap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg   <= 1'b0;
            ef_sel_reg <= '0;
            flip_h_reg <= 1'b0;
            flip_v_reg <= 1'b0;
            width_reg  <= '0;
            height_reg <= '0;
            x_mark_reg <= 1'b0;
            y_mark_reg <= 1'b0;
            x_org_reg  <= '0;
            y_org_reg  <= '0;
            hi_mid_reg <= '0;
            hi_top_reg <= '0;
            d_sel_reg  <= '0;
            base_reg   <= '0;
            bank_reg   <= '0;
        end
        else if (cmd.accept)
        begin
            if (action == ACT_VBLANK)
            begin
                disp_reg <= ~disp_reg;
            end
            if (action == ACT_REG)
            begin
                unique case (reg_index)
                    REG_MODE:
                    begin
                        ef_sel_reg <= value[3:0];
                        flip_h_reg <= value[4];
                        flip_v_reg <= value[5];
                    end
                    REG_WIDTH:
                    begin
                        width_reg  <= value[6:0];
                        x_mark_reg <= value[7];
                    end
                    REG_HEIGHT:
                    begin
                        height_reg <= value[6:0];
                        y_mark_reg <= value[7];
                    end
                    REG_XORG:    x_org_reg <= value;
                    REG_YORG:    y_org_reg <= value;
                    REG_HI:
                    begin
                        hi_mid_reg <= value[3:0];
                        hi_top_reg <= value[5:4];
                    end
                    REG_DSEL:    d_sel_reg <= value[5:0];
                    REG_BASE_LO: base_reg[7:0] <= value;
                    REG_BASE_HI: base_reg[15:8] <= value;
                    REG_DRAW:    bank_reg <= value[5:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // counters and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((cmd.step == STEP_CLEAR) || (cmd.step == STEP_FILL))
            begin
                sweep_reg <= sweep_reg + 17'd1;
            end
            else
            begin
                sweep_reg <= '0;
            end

            if (cmd.accept)
            begin
                y_reg <= '0;
            end
            else if ((cmd.step == STEP_D5) && sts.x_last)
            begin
                y_reg <= y_reg + 7'd1;
            end

            if (cmd.step == STEP_R5)
            begin
                x_reg <= '0;
            end
            else if (cmd.step == STEP_D5)
            begin
                x_reg <= x_reg + 7'd1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_x_reg <= pixel_x;
            rd_y_reg <= pixel_y;
        end
        if (cmd.out_load)
        begin
            pixel_reg <= map_rd;
        end
        unique case (cmd.step)
            STEP_R1: line_reg    <= rom_rd[6:0];
            STEP_R2: adda_lo_reg <= rom_rd;
            STEP_R3: sumb_reg    <= {4'b0, rom_rd[3:0], adda_lo_reg} + base_reg;
            STEP_R4: rowx_reg    <= inv_add(flip_v_reg, rom_rd, {2'b0, x_mark_reg, x_org_reg});
            STEP_R5: rowy_reg    <= inv_add(flip_v_reg, rom_rd, {2'b0, y_mark_reg, y_org_reg});
            STEP_D1: dv_reg      <= rom_rd;
            STEP_D2: px_reg      <= inv_add(flip_h_reg, rom_rd, rowx_reg);
            STEP_D3: py_reg      <= inv_add(flip_h_reg, rom_rd, rowy_reg);
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;

    assign sts.go_draw    = (action == ACT_REG) && (reg_index == REG_DRAW)
                            && (width_reg != '0) && (height_reg != '0);
    assign sts.go_fill    = (action == ACT_VBLANK);
    assign sts.go_read    = (action == ACT_READ);
    assign sts.x_last     = (x_reg == width_reg - 7'd1);
    assign sts.y_last     = (y_reg == height_reg - 7'd1);
    assign sts.clear_last = (sweep_reg == '1);
    assign sts.fill_last  = (sweep_reg[15:0] == '1);
    assign sts.out_busy   = out_valid_reg && out_stall;

endmodule

`default_nettype wire

// ===== rtl/sprite_blitter_double_buffer_core.sv =====
// ----------------------------------------------------------------------------
// sprite_blitter_double_buffer_core
// sprite drawing engine with two 256x256 nibble buffers
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall) takes one word per item: rom byte load,
// colour ram write, control register write, end of vblank or pixel read.
// output channel (out_valid / out_stall) carries one pixel word per read.
// after reset the block clears both sprite buffers, one nibble a cycle, and
// holds in_stall high until the clear is done.
// rom, colour ram and plain register writes leave in_stall low.
// a pixel read passes through a read state and a done state; its word sits
// in an output register until taken, and a further read waits while
// out_stall holds that register. end of vblank swaps the buffers and fills
// the new back buffer with 15 at one nibble a cycle.
// writing register 9 draws width x height dots when both are nonzero: six
// setup steps per row and six steps per dot, set by the single read port
// of the graphics rom.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blitter_double_buffer_core
    import sbdb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  action,
    input  wire logic [16:0] rom_address,
    input  wire logic [9:0]  color_address,
    input  wire logic [3:0]  reg_index,
    input  wire logic [7:0]  value,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [3:0]  pixel
);

    cmd_t cmd;
    sts_t sts;

    sbdb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbdb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .action        (action),
        .rom_address   (rom_address),
        .color_address (color_address),
        .reg_index     (reg_index),
        .value         (value),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel         (pixel),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

`default_nettype wire
